/* src/point_in_convex_hull_test_assert.svh */
// Assertion macros shared by the hull test modules.
// PICH_ASSERT checks that a property holds at every clock edge out of reset.
// PICH_NEVER checks that a condition is never true at a clock edge out of reset.
`ifndef POINT_IN_CONVEX_HULL_TEST_ASSERT_SVH
`define POINT_IN_CONVEX_HULL_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define PICH_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("hull test assertion failed");
`define PICH_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("hull test forbidden condition");
`else
`define PICH_ASSERT(label, clk, rst_n, prop)
`define PICH_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* src/pich_pkg.sv */
package pich_pkg;

	// field widths
	localparam int COORD_W  = 16;
	localparam int NORM_W   = 16;
	localparam int OFFS_W   = 34;
	localparam int RAD_W    = 35;
	localparam int BOX_W    = 3 * COORD_W;
	localparam int CNT_W    = 7;
	localparam int FIDX_W   = 6;

	// face table
	localparam int MAX_FACES = 64;
	localparam int IDX_W     = $clog2(MAX_FACES);

	// arithmetic widths
	localparam int SQ_W   = 2 * COORD_W;
	localparam int R2_W   = SQ_W + 2;
	localparam int PROD_W = COORD_W + NORM_W;

	// front/back queue
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);

	// configuration port
	localparam int APB_AW = 6;
	localparam int APB_DW = 64;

	typedef enum logic [2:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_CENTER_Z   = 3'd2,
		REG_RADIUS_SQ  = 3'd3,
		REG_BOX_LOWER  = 3'd4,
		REG_BOX_UPPER  = 3'd5,
		REG_FACE_COUNT = 3'd6
	} reg_idx_t;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		RSN_INSIDE = 2'd0,
		RSN_SPHERE = 2'd1,
		RSN_BOX    = 2'd2,
		RSN_FACE   = 2'd3
	} reason_t;

	typedef struct packed {
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic [COORD_W-1:0] center_z;
		logic [RAD_W-1:0]   radius_sq;
		logic [BOX_W-1:0]   box_lower;
		logic [BOX_W-1:0]   box_upper;
		logic [CNT_W-1:0]   face_count;
	} cfg_t;

	// one request as it travels from front to back
	typedef struct packed {
		action_t             action;
		logic [FIDX_W-1:0]   face_index;
		logic [NORM_W-1:0]   normal_x;
		logic [NORM_W-1:0]   normal_y;
		logic [NORM_W-1:0]   normal_z;
		logic [OFFS_W-1:0]   plane_offset;
		logic [COORD_W-1:0]  point_x;
		logic [COORD_W-1:0]  point_y;
		logic [COORD_W-1:0]  point_z;
		reason_t             reason;
	} q_item_t;

	typedef struct packed {
		logic [NORM_W-1:0] normal_x;
		logic [NORM_W-1:0] normal_y;
		logic [NORM_W-1:0] normal_z;
		logic [OFFS_W-1:0] plane_offset;
	} face_t;

endpackage

/* src/pich_ifs.sv */
// request channel into the block
interface pich_in_if;
	import pich_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       action;
	logic [FIDX_W-1:0]          face_index;
	logic signed [NORM_W-1:0]   normal_x;
	logic signed [NORM_W-1:0]   normal_y;
	logic signed [NORM_W-1:0]   normal_z;
	logic signed [OFFS_W-1:0]   plane_offset;
	logic signed [COORD_W-1:0]  point_x;
	logic signed [COORD_W-1:0]  point_y;
	logic signed [COORD_W-1:0]  point_z;

	modport source (output valid, action, face_index, normal_x, normal_y, normal_z,
		plane_offset, point_x, point_y, point_z, input ready);
	modport sink (input valid, action, face_index, normal_x, normal_y, normal_z,
		plane_offset, point_x, point_y, point_z, output ready);
endinterface

// result channel out of the block
interface pich_out_if;
	logic       valid;
	logic       ready;
	logic       inside_res;
	logic [1:0] reject_reason;

	modport source (output valid, inside_res, reject_reason, input ready);
	modport sink (input valid, inside_res, reject_reason, output ready);
endinterface

/* src/pich_cfg.sv */
module pich_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pich_pkg::APB_AW-1:0] paddr,
	input  logic [pich_pkg::APB_DW-1:0] pwdata,
	output logic [pich_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output pich_pkg::cfg_t              cfg
);
	import pich_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x   <= '0;
			cfg_q.center_y   <= '0;
			cfg_q.center_z   <= '0;
			cfg_q.radius_sq  <= '1;
			cfg_q.box_lower  <= BOX_W'(48'd140735340838911);
			cfg_q.box_upper  <= BOX_W'(48'd140741783322624);
			cfg_q.face_count <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_CENTER_X:   cfg_q.center_x   <= pwdata[COORD_W-1:0];
				REG_CENTER_Y:   cfg_q.center_y   <= pwdata[COORD_W-1:0];
				REG_CENTER_Z:   cfg_q.center_z   <= pwdata[COORD_W-1:0];
				REG_RADIUS_SQ:  cfg_q.radius_sq  <= pwdata[RAD_W-1:0];
				REG_BOX_LOWER:  cfg_q.box_lower  <= pwdata[BOX_W-1:0];
				REG_BOX_UPPER:  cfg_q.box_upper  <= pwdata[BOX_W-1:0];
				REG_FACE_COUNT: cfg_q.face_count <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, signed registers sign extended
	always_comb begin
		case (idx)
			REG_CENTER_X:   prdata = APB_DW'($signed(cfg_q.center_x));
			REG_CENTER_Y:   prdata = APB_DW'($signed(cfg_q.center_y));
			REG_CENTER_Z:   prdata = APB_DW'($signed(cfg_q.center_z));
			REG_RADIUS_SQ:  prdata = APB_DW'($signed(cfg_q.radius_sq));
			REG_BOX_LOWER:  prdata = APB_DW'(cfg_q.box_lower);
			REG_BOX_UPPER:  prdata = APB_DW'(cfg_q.box_upper);
			REG_FACE_COUNT: prdata = APB_DW'(cfg_q.face_count);
			default:        prdata = '0;
		endcase
	end

endmodule

/* src/pich_front.sv */
module pich_front (
	input  logic              clk,
	input  logic              arst_n,
	pich_in_if.sink           item,
	input  pich_pkg::cfg_t    cfg,
	output logic              push,
	output pich_pkg::q_item_t push_data,
	input  logic              full
);
	import pich_pkg::*;

	logic                    adv;
	logic                    take;
	q_item_t                 in_item;
	logic signed [COORD_W-1:0] pt [3];
	logic signed [COORD_W-1:0] ctr [3];
	logic [COORD_W-1:0]      mag [3];
	logic                    box_out;

	logic                    vld_s1;
	q_item_t                 it_s1;
	logic [COORD_W-1:0]      mag_s1 [3];
	logic                    box_out_s1;

	logic                    vld_s2;
	q_item_t                 it_s2;
	logic [SQ_W-1:0]         sq_s2 [3];
	logic                    box_out_s2;

	logic [R2_W-1:0]         r2;
	logic                    sphere_out;

	// both stages move together when the last one can drain
	assign adv        = !vld_s2 || !full;
	assign item.ready = adv;
	assign take       = item.valid && adv;

	always_comb begin
		in_item.action       = action_t'(item.action);
		in_item.face_index   = item.face_index;
		in_item.normal_x     = item.normal_x;
		in_item.normal_y     = item.normal_y;
		in_item.normal_z     = item.normal_z;
		in_item.plane_offset = item.plane_offset;
		in_item.point_x      = item.point_x;
		in_item.point_y      = item.point_y;
		in_item.point_z      = item.point_z;
		in_item.reason       = RSN_INSIDE;
	end

	// distance magnitudes and box test per axis
	always_comb begin
		logic signed [COORD_W:0] diff;
		logic signed [COORD_W-1:0] lo;
		logic signed [COORD_W-1:0] hi;
		pt[0]  = item.point_x;
		pt[1]  = item.point_y;
		pt[2]  = item.point_z;
		ctr[0] = $signed(cfg.center_x);
		ctr[1] = $signed(cfg.center_y);
		ctr[2] = $signed(cfg.center_z);
		box_out = 1'b0;
		for (int k = 0; k < 3; k++) begin
			diff   = {pt[k][COORD_W-1], pt[k]} - {ctr[k][COORD_W-1], ctr[k]};
			mag[k] = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
			lo     = $signed(cfg.box_lower[k*COORD_W +: COORD_W]);
			hi     = $signed(cfg.box_upper[k*COORD_W +: COORD_W]);
			if (pt[k] < lo || pt[k] > hi)
				box_out = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: captured request; stage 2: squared distances
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1      <= in_item;
			box_out_s1 <= box_out;
			it_s2      <= it_s1;
			box_out_s2 <= box_out_s1;
			for (int k = 0; k < 3; k++) begin
				mag_s1[k] <= mag[k];
				sq_s2[k]  <= mag_s1[k] * mag_s1[k];
			end
		end
	end

	// sphere test wins over the box test
	assign r2 = R2_W'(sq_s2[0]) + R2_W'(sq_s2[1]) + R2_W'(sq_s2[2]);
	assign sphere_out = cfg.radius_sq[RAD_W-1] || (RAD_W'(r2) > cfg.radius_sq);

	always_comb begin
		push_data = it_s2;
		if (sphere_out)
			push_data.reason = RSN_SPHERE;
		else if (box_out_s2)
			push_data.reason = RSN_BOX;
		else
			push_data.reason = RSN_INSIDE;
	end

	assign push = vld_s2 && !full;

endmodule

/* src/pich_fifo.sv */
`include "point_in_convex_hull_test_assert.svh"

module pich_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pich_pkg::q_item_t push_data,
	output logic              full,
	input  logic              pop,
	output pich_pkg::q_item_t pop_data,
	output logic              avail
);
	import pich_pkg::*;

	q_item_t           ent_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full     = cnt_q == (QPTR_W+1)'(Q_DEPTH);
	assign avail    = cnt_q != '0;
	assign pop_data = ent_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_data;
	end

	`PICH_NEVER(a_no_overflow, clk, arst_n, push && full)
	`PICH_NEVER(a_no_underflow, clk, arst_n, pop && !avail)

endmodule

/* src/pich_back.sv */
`include "point_in_convex_hull_test_assert.svh"

module pich_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        avail,
	input  pich_pkg::q_item_t           pop_data,
	output logic                        pop,
	input  logic [pich_pkg::CNT_W-1:0]  face_count,
	pich_out_if.source                  result
);
	import pich_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t               state_q;
	logic                 issue_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [IDX_W-1:0]     last_idx_q;
	logic signed [COORD_W-1:0] pt_x_q;
	logic signed [COORD_W-1:0] pt_y_q;
	logic signed [COORD_W-1:0] pt_z_q;
	reason_t              pend_q;
	logic                 res_valid_q;
	reason_t              res_reason_q;

	face_t                face_mem_q [MAX_FACES];

	logic                 rd_vld_s1;
	face_t                rd_face_s1;
	logic                 last_s1;

	logic                 vld_s2;
	logic signed [PROD_W-1:0] prod_x_s2;
	logic signed [PROD_W-1:0] prod_y_s2;
	logic signed [PROD_W-1:0] prod_z_s2;
	logic signed [OFFS_W-1:0] offset_s2;
	logic                 last_s2;

	logic                 is_query;
	logic                 mem_we;
	logic                 rd_en;
	logic [CNT_W-1:0]     fc_lim;
	logic signed [OFFS_W-1:0] dot;
	logic                 hit;
	logic                 done;
	logic                 out_free;

	assign is_query = pop_data.action == ACT_QUERY;
	assign pop      = (state_q == S_IDLE) && avail;
	assign mem_we   = pop && !is_query && (32'(pop_data.face_index) < 32'(MAX_FACES));
	assign fc_lim   = (face_count > CNT_W'(MAX_FACES)) ? CNT_W'(MAX_FACES) : face_count;
	assign rd_en    = (state_q == S_WALK) && issue_q && !done;
	assign out_free = !res_valid_q || result.ready;

	// plane test of the face at the end of the walk pipe
	assign dot  = OFFS_W'(prod_x_s2) + OFFS_W'(prod_y_s2) + OFFS_W'(prod_z_s2);
	assign hit  = dot <= offset_s2;
	assign done = vld_s2 && (hit || last_s2);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issue_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			vld_s2      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			vld_s2    <= rd_vld_s1 && !done;
			case (state_q)
				S_IDLE: begin
					if (pop && is_query) begin
						if (pop_data.reason != RSN_INSIDE || fc_lim == '0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_WALK;
							issue_q <= 1'b1;
						end
					end
				end
				S_WALK: begin
					if (rd_en && rd_idx_q == last_idx_q)
						issue_q <= 1'b0;
					if (done) begin
						issue_q <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_OUT && out_free)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	// query context, walk index and pending reason
	always_ff @(posedge clk) begin
		if (pop && is_query) begin
			pt_x_q     <= $signed(pop_data.point_x);
			pt_y_q     <= $signed(pop_data.point_y);
			pt_z_q     <= $signed(pop_data.point_z);
			pend_q     <= pop_data.reason;
			rd_idx_q   <= '0;
			last_idx_q <= IDX_W'(fc_lim - 1'b1);
		end else begin
			if (rd_en)
				rd_idx_q <= rd_idx_q + 1'b1;
			if (done)
				pend_q <= hit ? RSN_FACE : RSN_INSIDE;
		end
		if (state_q == S_OUT && out_free)
			res_reason_q <= pend_q;
	end

	// face table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			face_mem_q[IDX_W'(pop_data.face_index)] <= {pop_data.normal_x, pop_data.normal_y,
				pop_data.normal_z, pop_data.plane_offset};
		end
		if (rd_en) begin
			rd_face_s1 <= face_mem_q[rd_idx_q];
			last_s1    <= rd_idx_q == last_idx_q;
		end
	end

	// dot product lanes
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			prod_x_s2 <= pt_x_q * $signed(rd_face_s1.normal_x);
			prod_y_s2 <= pt_y_q * $signed(rd_face_s1.normal_y);
			prod_z_s2 <= pt_z_q * $signed(rd_face_s1.normal_z);
			offset_s2 <= $signed(rd_face_s1.plane_offset);
			last_s2   <= last_s1;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.inside_res    = res_reason_q == RSN_INSIDE;
	assign result.reject_reason = res_reason_q;

	`PICH_ASSERT(a_pipe_in_walk, clk, arst_n, (rd_vld_s1 || vld_s2) |-> state_q == S_WALK)
	`PICH_ASSERT(a_load_no_result, clk, arst_n, (pop && !is_query) |=> !$rose(res_valid_q))

endmodule

/* src/point_in_convex_hull_test.sv */
// Point-in-convex-hull test. Load requests write one face plane into a 64-entry
// face table and give no result; query requests give one result each: rejected by
// the bounding sphere, then by the inclusive box, then by the first face whose dot
// product with the point is at most the face offset, else inside. A front pipeline
// does the sphere and box tests and feeds a four-entry queue; the back end pops
// one request at a time. A query rejected by sphere or box, or tested against no
// faces, skips the face walk; a face walk reads up to n = min(face_count, 64)
// faces from the face table read port, one face per cycle, and stops at the
// first rejecting face. The face table has no reset: configure face_count only
// over faces that were loaded. Registers sit at byte address 8*i on a 64-bit
// APB-style port and are to be written only while idle; the block does not check.
module point_in_convex_hull_test (
	input  logic                        clk,
	input  logic                        arst_n,
	pich_in_if.sink                     item,
	pich_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pich_pkg::APB_AW-1:0] paddr,
	input  logic [pich_pkg::APB_DW-1:0] pwdata,
	output logic [pich_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import pich_pkg::*;

	cfg_t    cfg;
	logic    push;
	q_item_t push_data;
	logic    full;
	logic    pop;
	q_item_t pop_data;
	logic    avail;

	pich_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pich_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (cfg),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	pich_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.avail     (avail)
	);

	pich_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.avail      (avail),
		.pop_data   (pop_data),
		.pop        (pop),
		.face_count (cfg.face_count),
		.result     (result)
	);

endmodule
